@@ hdl/fir_pkg.sv @@
// fir_pkg: shared types and codes for the FIR filter core.
// No dependencies; used by fir_seq, fir_mac and fir_filter_core.
`default_nettype none

package fir_pkg;

    // Command codes carried in the input tuser field
    localparam int unsigned CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COEF  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Register map: index is paddr[2]
    localparam logic REG_TAP_COUNT = 1'b0;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } seq_state_t;

    // Control that travels alongside one tap through the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

`default_nettype wire

@@ hdl/fir_ram.sv @@
// fir_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fir_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/fir_mac.sv @@
// fir_mac: shared multiply-accumulate unit, one tap per cycle.
// Depends on fir_pkg (mac_ctl_t). Control is aligned with RAM read issue.
`default_nettype none

module fir_mac #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned COEFF_WIDTH  = 18,
    parameter int unsigned ACC_WIDTH    = 40
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire fir_pkg::mac_ctl_t       ctl,       // issued with the RAM read address
    input  wire logic [SAMPLE_WIDTH-1:0] sample,    // RAM read data, in the cycle after ctl
    input  wire logic [COEFF_WIDTH-1:0]  coeff,
    output      logic [ACC_WIDTH-1:0]    acc,
    output      logic                    acc_valid
);

    localparam int unsigned PROD_W = SAMPLE_WIDTH + COEFF_WIDTH;

    fir_pkg::mac_ctl_t             rd_ctl_reg;
    fir_pkg::mac_ctl_t             prod_ctl_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_WIDTH-1:0]   acc_reg;
    logic signed [ACC_WIDTH-1:0]   acc_next;
    logic signed [ACC_WIDTH-1:0]   prod_ext;
    logic                          acc_valid_reg;

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ctl_reg    <= '0;
            prod_ctl_reg  <= '0;
            acc_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ctl_reg   <= ctl;
            prod_ctl_reg <= rd_ctl_reg;
            if (ctl.valid && ctl.first)
            begin
                acc_valid_reg <= 1'b0;
            end
            else if (prod_ctl_reg.valid && prod_ctl_reg.last)
            begin
                acc_valid_reg <= 1'b1;
            end
        end
    end

    assign prod_ext = ACC_WIDTH'(prod_reg);
    assign acc_next = prod_ctl_reg.first ? prod_ext : acc_reg + prod_ext;

    // datapath
    always_ff @(posedge clk)
    begin
        if (rd_ctl_reg.valid)
        begin
            prod_reg <= $signed(sample) * $signed(coeff);
        end
        if (prod_ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc       = acc_reg;
    assign acc_valid = acc_valid_reg;

endmodule

`default_nettype wire

@@ hdl/fir_seq.sv @@
// fir_seq: command decode, history pointers and tap sequencer.
// Depends on fir_pkg (commands, states, mac_ctl_t).
`default_nettype none

module fir_seq #(
    parameter int unsigned MAX_TAPS = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output      logic                             in_ready,
    input  wire logic [fir_pkg::CMD_W-1:0]        command,
    input  wire logic [$clog2(MAX_TAPS)-1:0]      coeff_index,
    input  wire logic [$clog2(MAX_TAPS+1)-1:0]    tap_count,
    input  wire logic                             acc_valid,
    input  wire logic                             out_free,
    output      logic                             hist_we,
    output      logic [$clog2(MAX_TAPS)-1:0]      hist_waddr,
    output      logic [$clog2(MAX_TAPS)-1:0]      hist_raddr,
    output      logic                             coef_we,
    output      logic [$clog2(MAX_TAPS)-1:0]      coef_raddr,
    output      fir_pkg::mac_ctl_t                mac_ctl,
    output      logic                             load_out
);

    localparam int unsigned AW   = $clog2(MAX_TAPS);
    localparam int unsigned TC_W = $clog2(MAX_TAPS + 1);
    localparam logic [TC_W-1:0] MAX_TC = TC_W'(MAX_TAPS);
    localparam logic [AW-1:0]   LAST_SLOT = AW'(MAX_TAPS - 1);

    fir_pkg::seq_state_t state_reg, state_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [TC_W-1:0] fill_reg, fill_next;
    logic [AW-1:0]   rd_addr_reg, rd_addr_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [AW-1:0]   last_k_reg, last_k_next;

    logic            accept;
    logic [TC_W-1:0] taps_eff;
    logic [AW-1:0]   wp_inc;
    logic [TC_W-1:0] fill_inc;
    logic [TC_W:0]   wp_ext;
    logic [TC_W:0]   start_full;
    logic            k_last;

    // out-of-range tap counts clamp to 1..MAX_TAPS
    always_comb
    begin
        if (tap_count == '0)
        begin
            taps_eff = TC_W'(1);
        end
        else if (tap_count > MAX_TC)
        begin
            taps_eff = MAX_TC;
        end
        else
        begin
            taps_eff = tap_count;
        end
    end

    assign in_ready = (state_reg == fir_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign wp_inc   = (wp_reg == LAST_SLOT) ? '0 : wp_reg + AW'(1);
    assign fill_inc = (fill_reg < MAX_TC) ? fill_reg + TC_W'(1) : fill_reg;

    // oldest sample of the window: write pointer minus window length, mod MAX_TAPS
    assign wp_ext     = (TC_W + 1)'(wp_inc);
    assign start_full = (wp_ext >= (TC_W + 1)'(taps_eff))
                        ? wp_ext - (TC_W + 1)'(taps_eff)
                        : wp_ext + (TC_W + 1)'(MAX_TAPS) - (TC_W + 1)'(taps_eff);

    assign k_last = (k_reg == last_k_reg);

    assign hist_we    = accept && (command == fir_pkg::CMD_PUSH);
    assign hist_waddr = wp_reg;
    assign coef_we    = accept && (command == fir_pkg::CMD_COEF)
                        && ((TC_W)'(coeff_index) < MAX_TC);
    assign hist_raddr = rd_addr_reg;
    assign coef_raddr = k_reg;

    assign mac_ctl.valid = (state_reg == fir_pkg::ST_RUN);
    assign mac_ctl.first = (k_reg == '0);
    assign mac_ctl.last  = k_last;

    assign load_out = (state_reg == fir_pkg::ST_DRAIN) && acc_valid && out_free;

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        rd_addr_next = rd_addr_reg;
        k_next       = k_reg;
        last_k_next  = last_k_reg;
        case (state_reg)
            fir_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        fir_pkg::CMD_PUSH:
                        begin
                            wp_next   = wp_inc;
                            fill_next = fill_inc;
                            if (fill_inc >= taps_eff)
                            begin
                                rd_addr_next = start_full[AW-1:0];
                                k_next       = '0;
                                last_k_next  = AW'(taps_eff - TC_W'(1));
                                state_next   = fir_pkg::ST_RUN;
                            end
                        end
                        fir_pkg::CMD_CLEAR:
                        begin
                            wp_next   = '0;
                            fill_next = '0;
                        end
                        default:
                        begin
                            // coefficient write goes straight to the RAM; code 3 is a no-op
                        end
                    endcase
                end
            end
            fir_pkg::ST_RUN:
            begin
                rd_addr_next = (rd_addr_reg == LAST_SLOT) ? '0 : rd_addr_reg + AW'(1);
                k_next       = k_reg + AW'(1);
                if (k_last)
                begin
                    state_next = fir_pkg::ST_DRAIN;
                end
            end
            fir_pkg::ST_DRAIN:
            begin
                if (load_out)
                begin
                    state_next = fir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fir_pkg::ST_IDLE;
            wp_reg      <= '0;
            fill_reg    <= '0;
            rd_addr_reg <= '0;
            k_reg       <= '0;
            last_k_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            rd_addr_reg <= rd_addr_next;
            k_reg       <= k_next;
            last_k_reg  <= last_k_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= MAX_TC)
        else $error("fill count above window capacity");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_SLOT)
        else $error("history write pointer out of range");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fir_pkg::ST_RUN) |-> (k_reg <= last_k_reg))
        else $error("tap counter ran past the window");

    a_acc_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(acc_valid) |-> (state_reg == fir_pkg::ST_DRAIN))
        else $error("accumulator finished outside drain");

endmodule

`default_nettype wire

@@ hdl/fir_filter_core.sv @@
// fir_filter_core: top level of the streaming fixed-point FIR filter.
// Depends on fir_pkg, fir_ram, fir_mac and fir_seq.
`default_nettype none

// Direct-form FIR filter with one shared multiply-accumulate unit. Each input
// word carries a command in tuser: push a Q1.15 sample, write a Q2.16
// coefficient, or clear the sample history. Once tap_count samples have been
// pushed since the last clear, every push yields one output word holding the
// exact Q9.31 sum of products, coefficient 0 on the oldest sample of the
// window. Coefficient writes, clears and pushes that yield no output complete
// as they are accepted, with s_axis_tready high. For a push that yields an
// output, the sequencer steps the MAC through one tap per cycle, reading the
// history and coefficient RAMs on their single read ports, and then waits out
// the read/multiply/accumulate pipeline and the load of the output register.
// s_axis_tready stays low for that time. The output register frees the input
// side: a finished word may wait on m_axis_tready while new words are taken,
// but the next result holds the sequencer until the register is free.
// Coefficients are undefined after reset and must be written before use.
// tap_count (APB offset 0x0) resets to MAX_TAPS; 0 acts as 1 and values above
// MAX_TAPS act as MAX_TAPS. Write it only while the block is idle.
module fir_filter_core #(
    parameter int unsigned MAX_TAPS     = 64,
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned COEFF_WIDTH  = 18
) (
    input  wire logic clk,
    input  wire logic rst_n,

    // input stream
    input  wire logic s_axis_tvalid,
    output      logic s_axis_tready,
    // tdata: sample, coeff_index, coeff_value (low to high), zero padded
    input  wire logic [((SAMPLE_WIDTH + $clog2(MAX_TAPS) + COEFF_WIDTH + 7) / 8) * 8 - 1:0]
                      s_axis_tdata,
    // tuser: command
    input  wire logic [fir_pkg::CMD_W-1:0] s_axis_tuser,

    // output stream
    output      logic m_axis_tvalid,
    input  wire logic m_axis_tready,
    // tdata: filtered, zero padded
    output      logic [((SAMPLE_WIDTH + COEFF_WIDTH + $clog2(MAX_TAPS) + 7) / 8) * 8 - 1:0]
                      m_axis_tdata,

    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fir_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [fir_pkg::APB_DATA_W-1:0]  pwdata,
    output      logic [fir_pkg::APB_DATA_W-1:0]  prdata,
    output      logic                            pready
);

    localparam int unsigned AW     = $clog2(MAX_TAPS);
    localparam int unsigned TC_W   = $clog2(MAX_TAPS + 1);
    localparam int unsigned OUT_W  = SAMPLE_WIDTH + COEFF_WIDTH + AW;
    localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int unsigned IDX_LO = SAMPLE_WIDTH;
    localparam int unsigned CV_LO  = SAMPLE_WIDTH + AW;

    // input word fields
    logic [SAMPLE_WIDTH-1:0] in_sample;
    logic [AW-1:0]           in_coeff_index;
    logic [COEFF_WIDTH-1:0]  in_coeff_value;

    assign in_sample      = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign in_coeff_index = s_axis_tdata[CV_LO-1:IDX_LO];
    assign in_coeff_value = s_axis_tdata[CV_LO+COEFF_WIDTH-1:CV_LO];

    // config register
    logic [TC_W-1:0] tap_count_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == fir_pkg::REG_TAP_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TC_W'(MAX_TAPS);
        end
        else if (cfg_wr)
        begin
            tap_count_reg <= pwdata[TC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == fir_pkg::REG_TAP_COUNT)
                    ? fir_pkg::APB_DATA_W'(tap_count_reg) : '0;

    // sequencer <-> RAMs and MAC
    logic              hist_we;
    logic [AW-1:0]     hist_waddr;
    logic [AW-1:0]     hist_raddr;
    logic              coef_we;
    logic [AW-1:0]     coef_raddr;
    fir_pkg::mac_ctl_t mac_ctl;
    logic              load_out;
    logic              out_free;
    logic [SAMPLE_WIDTH-1:0] hist_rdata;
    logic [COEFF_WIDTH-1:0]  coef_rdata;
    logic [OUT_W-1:0]  acc;
    logic              acc_valid;

    fir_seq #(
        .MAX_TAPS (MAX_TAPS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .command     (s_axis_tuser),
        .coeff_index (in_coeff_index),
        .tap_count   (tap_count_reg),
        .acc_valid   (acc_valid),
        .out_free    (out_free),
        .hist_we     (hist_we),
        .hist_waddr  (hist_waddr),
        .hist_raddr  (hist_raddr),
        .coef_we     (coef_we),
        .coef_raddr  (coef_raddr),
        .mac_ctl     (mac_ctl),
        .load_out    (load_out)
    );

    // sample history, circular
    fir_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (in_sample),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // coefficient table
    fir_ram #(
        .WIDTH (COEFF_WIDTH),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (in_coeff_index),
        .wdata (in_coeff_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    fir_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEFF_WIDTH  (COEFF_WIDTH),
        .ACC_WIDTH    (OUT_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mac_ctl),
        .sample    (hist_rdata),
        .coeff     (coef_rdata),
        .acc       (acc),
        .acc_valid (acc_valid)
    );

    // output register: one word of slack between the MAC and the consumer
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= acc;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TW'(out_data_reg);

endmodule

`default_nettype wire
